// ----- sv/escaped_frame_receiver_assert.svh -----
// Assertion macros for the escaped frame receiver.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define EFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EFR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EFR_ASSERT(lbl, prop, msg)
`define EFR_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/efr_pkg.sv -----
// Shared types and constants for the escaped frame receiver.
// No dependencies.
package efr_pkg;

    localparam int unsigned BYTE_W = 8;

    // register map: index taken from paddr[2]
    localparam logic REG_SYNC   = 1'b0;
    localparam logic REG_ESCAPE = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hE0;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'hD0;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] node_address;
        logic [BYTE_W-1:0] byte_index;
        logic              last_of_frame;
    } efr_result_t;

endpackage

// ----- sv/escaped_frame_receiver.sv -----
// Escaped frame receiver: sync hunt, header capture and escape removal.
// Depends on efr_pkg and escaped_frame_receiver_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one raw serial byte per
//   word. Bytes are dropped until the sync byte arrives; the next two bytes
//   are the node address and the size. Size minus one (mod 256) payload bytes
//   follow, each delivered on the output channel (out_valid/out_ready) with
//   node_address, byte_index and last_of_frame. An escape byte inside the
//   payload is dropped and the byte after it is delivered plus one. The
//   checksum byte after the payload is swallowed by the next hunt.
//   Throughput: one byte per cycle while the skid register is empty, set by the
//   single-pass state update from the header/count registers to the result register.
//   A two-deep output stage (result register plus skid register) lets input
//   keep flowing after the receiver stalls; in_ready drops
//   only while the skid register is occupied.
//   Reset: hunting for sync, output stage empty, sync 0xE0, escape 0xD0.
//   Configuration: APB, sync at 0x0, escape at 0x4; write only while idle.
module escaped_frame_receiver
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [efr_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [efr_pkg::BYTE_W-1:0]    payload_byte,
    output logic [efr_pkg::BYTE_W-1:0]    node_address,
    output logic [efr_pkg::BYTE_W-1:0]    byte_index,
    output logic                          last_of_frame,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

`include "escaped_frame_receiver_assert.svh"

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ADDR,
        PH_SIZE,
        PH_DATA,
        PH_ESCAPED
    } phase_t;

    localparam int unsigned W = efr_pkg::BYTE_W;

    // configuration
    logic [W-1:0] sync_reg;
    logic [W-1:0] escape_reg;

    // frame state
    phase_t       phase_reg,      phase_next;
    logic [W-1:0] bytes_left_reg, bytes_left_next;
    logic [W-1:0] index_reg,      index_next;
    logic [W-1:0] address_reg,    address_next;

    // output stage
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    efr_pkg::efr_result_t out_data_reg;
    efr_pkg::efr_result_t skid_data_reg;

    logic                 emit;
    efr_pkg::efr_result_t result;
    logic                 in_fire;
    logic                 res_fire;
    logic                 out_free;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == efr_pkg::REG_ESCAPE) ? {24'd0, escape_reg}
                                                         : {24'd0, sync_reg};

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign res_fire = in_fire && emit;
    assign out_free = !out_valid_reg || out_ready;

    // next frame state and the result of the byte at the input
    always_comb
    begin
        logic [W-1:0] value;
        logic         last;
        value           = rx_byte;
        last            = (bytes_left_reg == W'(1));
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        index_next      = index_reg;
        address_next    = address_reg;
        emit            = 1'b0;
        case (phase_reg)
            PH_ADDR:
            begin
                address_next = rx_byte;
                phase_next   = PH_SIZE;
            end
            PH_SIZE:
            begin
                bytes_left_next = rx_byte - W'(1);
                index_next      = '0;
                phase_next      = (rx_byte == W'(1)) ? PH_HUNT : PH_DATA;
            end
            PH_DATA:
            begin
                if (rx_byte == escape_reg)
                begin
                    phase_next = PH_ESCAPED;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_ESCAPED:
            begin
                value = rx_byte + W'(1);
                emit  = 1'b1;
            end
            default:
            begin
                phase_next = (rx_byte == sync_reg) ? PH_ADDR : PH_HUNT;
            end
        endcase
        if (emit)
        begin
            index_next      = index_reg + W'(1);
            bytes_left_next = bytes_left_reg - W'(1);
            phase_next      = last ? PH_HUNT : PH_DATA;
        end
        result.payload_byte  = value;
        result.node_address  = address_reg;
        result.byte_index    = index_reg;
        result.last_of_frame = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg       <= efr_pkg::SYNC_RESET;
            escape_reg     <= efr_pkg::ESCAPE_RESET;
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
            index_reg      <= '0;
            address_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_data_reg   <= '0;
            skid_data_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == efr_pkg::REG_SYNC)
                begin
                    sync_reg <= pwdata[W-1:0];
                end
                else
                begin
                    escape_reg <= pwdata[W-1:0];
                end
            end
            // advance frame state on each accepted byte
            if (in_fire)
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                index_reg      <= index_next;
                address_reg    <= address_next;
            end
            // output stage: drain the skid register first, keep order
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= res_fire;
                    skid_data_reg  <= result;
                end
                else
                begin
                    out_valid_reg <= res_fire;
                    out_data_reg  <= result;
                end
            end
            else if (res_fire)
            begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= result;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = out_data_reg.payload_byte;
    assign node_address  = out_data_reg.node_address;
    assign byte_index    = out_data_reg.byte_index;
    assign last_of_frame = out_data_reg.last_of_frame;

    `EFR_NEVER(a_skid_without_out, skid_valid_reg && !out_valid_reg,
               "skid register holds a word while the result register is empty")
    `EFR_ASSERT(a_data_emits, (in_fire && phase_reg == PH_DATA && rx_byte != escape_reg)
                |=> out_valid_reg, "payload byte accepted but no result presented")
    `EFR_ASSERT(a_addr_to_size, (in_fire && phase_reg == PH_ADDR) |=> phase_reg == PH_SIZE,
                "address byte not followed by size phase")
    `EFR_NEVER(a_count_live, (phase_reg == PH_DATA || phase_reg == PH_ESCAPED)
               && bytes_left_reg == '0, "payload phase with no bytes left")

endmodule
